// File: design/sla_pkg.sv
package sla_pkg;

  // Atlas geometry
  localparam int COLUMNS   = 256;
  localparam int ROWS      = 256;
  localparam int PAGES     = 2;
  localparam int MEM_DEPTH = PAGES * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);      // column index
  localparam int HGT_W  = $clog2(ROWS + 1);     // fill height, 0..ROWS
  localparam int PAGE_W = 1;                    // page_select field
  localparam int ADDR_W = $clog2(MEM_DEPTH);    // {page, column}

  // Field widths of the request and result words
  localparam int DIM_W  = 9;
  localparam int POS_W  = 8;
  localparam int MASK_W = 2;
  localparam int PAD_W  = 4;
  localparam int SUM_W  = ((HGT_W > DIM_W) ? HGT_W : DIM_W) + 1;

  localparam logic [PAD_W-1:0] PAD_RESET = PAD_W'(2);

  // Operation codes
  localparam logic OP_ALLOC  = 1'b0;
  localparam logic OP_UPLOAD = 1'b1;

  typedef struct packed {
    logic             operation;
    logic             page_select;
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
  } req_t;

  typedef struct packed {
    logic              success;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [MASK_W-1:0] dirty_mask;
  } res_t;

  // Sequencer -> scan unit
  typedef struct packed {
    logic             go;
    logic [COL_W-1:0] width;
  } scan_ctrl_t;

  // Scan unit -> sequencer
  typedef struct packed {
    logic             done;
    logic             found;
    logic [HGT_W-1:0] best;
    logic [COL_W-1:0] best_x;
  } scan_stat_t;

endpackage

// File: design/skyline_atlas_allocator_unit.sv
// Skyline atlas allocator, two pages of 256 x 256 texels, one fill height per column.
//
// Request channel: start with a req word (operation, page_select, rect_width,
// rect_height); the word is taken on a clock edge with start high and busy low.
// Result channel: done is high for exactly one cycle with the result word; the
// receiver cannot stall, so the word must be captured in that cycle.
// Config: cfg_we/cfg_wdata write page1_width_pad (extra columns on page 1);
// write only while the block is idle.
//
// Flow: an upload returns its word the cycle after acceptance and busy stays
// low, so a new word can follow at once. An allocation runs the skyline scan
// (skipped for a zero or oversize width), a check state and, when it fits
// with a nonzero width, a fill sweep over the covered columns. The scan reads
// one column a cycle from the height RAM through a single compare unit; it
// restarts past any column that cannot beat the best window and discards the
// read in flight each time an accepted window must be refetched. It runs
// longest when column heights fall off steadily.
// Reset: synchronous; afterwards a clearing pass zeroes all 512 heights with
// busy high. The dirty mask clears and the pad returns to 2.
module skyline_atlas_allocator_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  sla_pkg::req_t             req,
  output logic                      busy,
  output logic                      done,
  output sla_pkg::res_t             result,
  input  logic                      cfg_we,
  input  logic [sla_pkg::PAD_W-1:0] cfg_wdata
);
  import sla_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_FILL  = 5'b10000
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_addr;
  logic [PAD_W-1:0]  pad;
  logic [MASK_W-1:0] dirty;

  // Latched request
  logic [PAGE_W-1:0] page_r;
  logic [DIM_W-1:0]  height_r;
  logic [COL_W-1:0]  w_lo_r;

  // Chosen placement
  logic              found_r;
  logic [HGT_W-1:0]  best_r;
  logic [COL_W-1:0]  bx_r;

  // Fill sweep
  logic [COL_W-1:0]  fill_col;
  logic [COL_W-1:0]  fill_left;

  // Height RAM
  logic [HGT_W-1:0]  heights [MEM_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [HGT_W-1:0]  wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [HGT_W-1:0]  rd_data;

  logic [DIM_W:0]    w_eff;
  logic              w_big;
  logic              w_zero;
  logic [SUM_W-1:0]  new_top;
  logic              fits;
  res_t              ok_res;
  res_t              fail_res;

  scan_ctrl_t        scan_ctrl;
  scan_stat_t        scan_stat;
  logic [COL_W-1:0]  scan_col;

  assign busy = (state != ST_IDLE);

  // Effective width: page 1 gets the configured padding.
  assign w_eff  = {1'b0, req.rect_width} +
                  (req.page_select ? (DIM_W + 1)'(pad) : '0);
  assign w_big  = 32'(w_eff) >= COLUMNS;
  assign w_zero = (w_eff == '0);

  assign scan_ctrl = '{go: (state == ST_IDLE) && start && (req.operation == OP_ALLOC) &&
                           !w_big && !w_zero,
                       width: w_eff[COL_W-1:0]};

  sla_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (scan_ctrl),
    .rd_data (rd_data),
    .rd_col  (scan_col),
    .stat    (scan_stat)
  );

  // New top of the covered columns; the placement must stay within ROWS.
  assign new_top = SUM_W'(best_r) + SUM_W'(height_r);
  assign fits    = found_r && (new_top <= SUM_W'(ROWS));

  assign ok_res   = '{success: 1'b1, pos_x: POS_W'(bx_r), pos_y: best_r[POS_W-1:0],
                      dirty_mask: '0};
  assign fail_res = '{success: 1'b0, pos_x: '0, pos_y: '0, dirty_mask: '0};

  // RAM ports: clear pass and fill sweep write; scan reads.
  assign mem_we  = (state == ST_CLEAR) || (state == ST_FILL);
  assign wr_addr = (state == ST_CLEAR) ? clr_addr : {page_r, fill_col};
  assign wr_data = (state == ST_CLEAR) ? '0 : new_top[HGT_W-1:0];
  assign rd_addr = {page_r, scan_col};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heights[wr_addr] <= wr_data;
    end
    rd_data <= heights[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
      dirty    <= '0;
      pad      <= PAD_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        pad <= cfg_wdata;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (&clr_addr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            page_r   <= req.page_select;
            height_r <= req.rect_height;
            w_lo_r   <= w_eff[COL_W-1:0];
            if (req.operation == OP_UPLOAD) begin
              // report and clear the mask in one go
              done   <= 1'b1;
              result <= '{success: 1'b1, pos_x: '0, pos_y: '0, dirty_mask: dirty};
              dirty  <= '0;
            end else if (w_big) begin
              found_r <= 1'b0;
              state   <= ST_CHECK;
            end else if (w_zero) begin
              // empty window: column 0 at height 0 wins outright
              found_r <= 1'b1;
              best_r  <= '0;
              bx_r    <= '0;
              state   <= ST_CHECK;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_stat.done) begin
            found_r <= scan_stat.found;
            best_r  <= scan_stat.best;
            bx_r    <= scan_stat.best_x;
            state   <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (fits && (w_lo_r != '0)) begin
            fill_col  <= bx_r;
            fill_left <= w_lo_r;
            state     <= ST_FILL;
          end else begin
            done   <= 1'b1;
            result <= fits ? ok_res : fail_res;
            if (fits) begin
              dirty[page_r] <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        ST_FILL: begin
          fill_col  <= fill_col + COL_W'(1);
          fill_left <= fill_left - COL_W'(1);
          if (fill_left == COL_W'(1)) begin
            done          <= 1'b1;
            result        <= ok_res;
            dirty[page_r] <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A result word only ever follows an idle, check or fill cycle.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_IDLE || state == ST_CHECK || state == ST_FILL))
    else $error("result word from an unexpected state");

  // A nonzero mask belongs to an upload, which places nothing.
  a_mask_upload: assert property (@(posedge clk) disable iff (rst)
    (done && (result.dirty_mask != '0)) |->
      (result.success && (result.pos_x == '0) && (result.pos_y == '0)))
    else $error("dirty mask on an allocation word");

  // A successful placement leaves its page marked dirty.
  a_alloc_dirty: assert property (@(posedge clk) disable iff (rst)
    (done && result.success && (result.dirty_mask == '0) && !$past(start && !busy)) |->
      dirty[page_r])
    else $error("placed rectangle without dirty mark");

  // The scan unit reports only while the sequencer waits on it.
  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    scan_stat.done |-> (state == ST_SCAN))
    else $error("scan finished outside the scan state");

  // The fill sweep never runs with nothing left to write.
  a_fill_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (fill_left != '0))
    else $error("fill sweep underflow");

endmodule

// File: design/sla_scan.sv
module sla_scan (
  input  logic                      clk,
  input  logic                      rst,
  input  sla_pkg::scan_ctrl_t       ctrl,
  input  logic [sla_pkg::HGT_W-1:0] rd_data,
  output logic [sla_pkg::COL_W-1:0] rd_col,
  output sla_pkg::scan_stat_t       stat
);
  import sla_pkg::*;

  localparam int CW1 = COL_W + 1;
  localparam int CW2 = COL_W + 2;

  logic             active;
  logic             done;
  logic [COL_W-1:0] width_r;
  logic [CW1-1:0]   win_start;
  logic [CW1-1:0]   rd_next;
  logic             pend;
  logic [CW1-1:0]   pend_col;
  logic [HGT_W-1:0] win_max;
  logic [CW1-1:0]   max_col;
  logic [HGT_W-1:0] best;
  logic [COL_W-1:0] best_x;
  logic             found;

  logic             blocked;
  logic             take;
  logic [HGT_W-1:0] m_new;
  logic [CW1-1:0]   mc_new;
  logic [CW2-1:0]   win_end;
  logic             complete;
  logic [CW1-1:0]   next_start;
  logic             finish;
  logic             flush;

  // A column at or above the best height kills every window that covers it.
  assign blocked    = pend && (rd_data >= best);
  assign take       = rd_data >= win_max;
  assign m_new      = take ? rd_data : win_max;
  assign mc_new     = take ? pend_col : max_col;
  assign win_end    = CW2'(win_start) + CW2'(width_r) - CW2'(1);
  assign complete   = pend && !blocked && (CW2'(pend_col) == win_end);
  assign next_start = blocked ? (pend_col + CW1'(1)) : (mc_new + CW1'(1));
  assign finish     = (blocked || complete) &&
                      ((CW2'(next_start) + CW2'(width_r) >= CW2'(COLUMNS)) ||
                       (complete && (m_new == '0)));
  // restart behind the window's end: refetch from just past its tallest column
  assign flush      = complete && (mc_new != pend_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.go) begin
        active    <= 1'b1;
        width_r   <= ctrl.width;
        win_start <= '0;
        rd_next   <= '0;
        pend      <= 1'b0;
        win_max   <= '0;
        best      <= HGT_W'(ROWS);
        found     <= 1'b0;
      end else if (active) begin
        rd_next  <= rd_next + CW1'(1);
        pend     <= 1'b1;
        pend_col <= rd_next;
        if (flush) begin
          rd_next <= mc_new + CW1'(1);
          pend    <= 1'b0;
        end
        if (blocked) begin
          win_start <= next_start;
          win_max   <= '0;
        end else if (complete) begin
          best      <= m_new;
          best_x    <= win_start[COL_W-1:0];
          found     <= 1'b1;
          win_start <= next_start;
          win_max   <= '0;
        end else if (pend) begin
          win_max <= m_new;
          max_col <= mc_new;
        end
        if (finish) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign rd_col = rd_next[COL_W-1:0];
  assign stat   = '{done: done, found: found, best: best, best_x: best_x};

endmodule

// File: bench/skyline_atlas_allocator_unit_tb.sv
// Bench for the two-page skyline atlas allocator.
//
// Every word the block takes is run through a local model of both skylines,
// the dirty mask and the page 1 pad, and the expected result word is queued.
// A monitor on the done strobe pops the oldest expectation and compares it
// field by field.
module skyline_atlas_allocator_unit_tb;
  import sla_pkg::*;

  logic           clk;
  logic           rst;
  logic           start;
  req_t           req;
  logic           busy;
  logic           done;
  res_t           result;
  logic           cfg_we;
  logic [PAD_W-1:0] cfg_wdata;

  skyline_atlas_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Local copy of the atlas state.
  int               fill_height [PAGES][COLUMNS];
  logic [MASK_W-1:0] dirty_bits;
  logic [PAD_W-1:0]  pad_model;

  // Result words still owed by the block, oldest first.
  res_t owed_words[$];

  int errors;
  int placed_cnt;
  int no_room_cnt;
  int upload_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. A steadily falling skyline gives the longest scan per word; the
  // limit leaves ample margin even if all ~1300 words hit that case.
  initial begin
    #1_000_000_000;
    $display("skyline_atlas_allocator_unit verification failed");
    $finish;
  end

  // Model one accepted word: returns the result it must produce and updates
  // the local state exactly as the block should.
  function automatic res_t atlas_step(input req_t w);
    res_t r;
    int   pg;
    int   eff;
    int   best;
    int   bx;
    int   top;
    bit   found;
    r = '0;
    if (w.operation == OP_UPLOAD) begin
      r.success    = 1'b1;
      r.dirty_mask = dirty_bits;
      dirty_bits   = '0;
      upload_cnt++;
      return r;
    end
    pg  = int'(w.page_select);
    // Page 1 requests are widened by the pad.
    eff = int'(w.rect_width) + ((pg == 1) ? int'(pad_model) : 0);
    best  = ROWS;
    bx    = 0;
    found = 1'b0;
    // Start columns stop short of the last one; a full column never wins
    // because its window height can't be below ROWS.
    if (eff < COLUMNS) begin
      for (int i = 0; i < COLUMNS - eff; i++) begin
        top = 0;
        for (int j = 0; j < eff; j++)
          if (fill_height[pg][i+j] > top) top = fill_height[pg][i+j];
        if (top < best) begin
          best  = top;
          bx    = i;
          found = 1'b1;
        end
      end
    end
    if (!found || best + int'(w.rect_height) > ROWS) begin
      no_room_cnt++;
      return r;
    end
    // Zero width or zero height still counts as a placement and marks the page.
    for (int j = 0; j < eff; j++)
      fill_height[pg][bx+j] = best + int'(w.rect_height);
    dirty_bits[pg] = 1'b1;
    r.success = 1'b1;
    r.pos_x   = POS_W'(bx);
    r.pos_y   = POS_W'(best);
    placed_cnt++;
    return r;
  endfunction

  function automatic req_t make_word(input logic op, input logic pg,
                                     input int wd, input int ht);
    req_t w;
    w.operation   = op;
    w.page_select = pg;
    w.rect_width  = DIM_W'(wd);
    w.rect_height = DIM_W'(ht);
    return w;
  endfunction

  // Random request word. Small rectangles dominate so the skylines fill
  // gradually and the scan stays short; a few wide ones, zero sizes and
  // over-range sizes keep every bit of both dimension fields moving.
  function automatic req_t random_word();
    int   pick;
    int   wd;
    int   ht;
    logic op;
    op   = ($urandom_range(0, 9) == 0) ? OP_UPLOAD : OP_ALLOC;
    pick = $urandom_range(0, 99);
    if (pick < 68)      wd = $urandom_range(1, 16);
    else if (pick < 88) wd = $urandom_range(0, 64);
    else if (pick < 94) wd = $urandom_range(65, 255);
    else if (pick < 98) wd = $urandom_range(256, 511);
    else                wd = 0;
    pick = $urandom_range(0, 99);
    if (pick < 72)      ht = $urandom_range(1, 16);
    else if (pick < 88) ht = $urandom_range(0, 64);
    else if (pick < 93) ht = 0;
    else                ht = $urandom_range(65, 511);
    return make_word(op, 1'($urandom_range(0, 1)), wd, ht);
  endfunction

  // Offer one word and hold it until the block takes it. start is left high
  // afterwards; the next send or hold_off decides what happens to it.
  task automatic send_word(input req_t w);
    @(negedge clk);
    start <= 1'b1;
    req   <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    owed_words.push_back(atlas_step(w));
  endtask

  // Sender idles, start low, for the span given by n; the request bus carries junk meanwhile.
  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      req   <= req_t'($urandom);
    end
  endtask

  // Wait for the block to go quiet: nothing owed and busy low.
  task automatic drain();
    hold_off(1);
    while (owed_words.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Pad writes happen only with the block idle.
  task automatic write_pad(input logic [PAD_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= PAD_W'($urandom);
    pad_model = v;
  endtask

  // Result monitor: every done word must match the oldest owed word.
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && done) begin
      if (owed_words.size() == 0) begin
        $error("result word with nothing owed: %p", result);
        errors++;
      end else begin
        want = owed_words.pop_front();
        if (result.success !== want.success) begin
          $error("success: expected %0d, got %0d", want.success, result.success);
          errors++;
        end
        if (result.pos_x !== want.pos_x) begin
          $error("pos_x: expected %0d, got %0d", want.pos_x, result.pos_x);
          errors++;
        end
        if (result.pos_y !== want.pos_y) begin
          $error("pos_y: expected %0d, got %0d", want.pos_y, result.pos_y);
          errors++;
        end
        if (result.dirty_mask !== want.dirty_mask) begin
          $error("dirty_mask: expected %0d, got %0d", want.dirty_mask, result.dirty_mask);
          errors++;
        end
      end
    end
  end

  // Clean atlas after reset with the reset pad of 2: empty mask, zero and
  // oversize dimensions, a column filled to the top, no-room refusals.
  task automatic test_reset_pad_edges();
    send_word(make_word(OP_UPLOAD, 1'b0, 0, 0));     // mask clean after reset
    send_word(make_word(OP_ALLOC, 1'b0, 1, 1));
    send_word(make_word(OP_ALLOC, 1'b0, 1, 256));    // full height on flat ground
    send_word(make_word(OP_ALLOC, 1'b0, 255, 1));    // widest that still scans
    send_word(make_word(OP_ALLOC, 1'b0, 256, 1));    // too wide
    send_word(make_word(OP_ALLOC, 1'b0, 511, 511));  // both fields at max
    send_word(make_word(OP_ALLOC, 1'b0, 0, 5));      // zero width
    send_word(make_word(OP_ALLOC, 1'b0, 4, 0));      // zero height
    send_word(make_word(OP_ALLOC, 1'b0, 1, 256));    // full height again, beside the full column
    send_word(make_word(OP_ALLOC, 1'b0, 1, 200));
    send_word(make_word(OP_ALLOC, 1'b0, 2, 0));
    send_word(make_word(OP_UPLOAD, 1'b1, 0, 0));     // page 0 dirty only
    send_word(make_word(OP_ALLOC, 1'b1, 254, 3));    // pad pushes it to 256
    send_word(make_word(OP_ALLOC, 1'b1, 253, 3));
    send_word(make_word(OP_ALLOC, 1'b1, 0, 1));      // zero width plus pad
    send_word(make_word(OP_ALLOC, 1'b1, 1, 300));    // taller than the page
    send_word(make_word(OP_UPLOAD, 1'b0, 0, 0));
    send_word(make_word(OP_UPLOAD, 1'b0, 0, 0));     // cleared by the last read
  endtask

  // Pad at both ends of its range, each with a word right at the width limit.
  task automatic test_pad_extremes();
    write_pad(PAD_W'(15));
    send_word(make_word(OP_ALLOC, 1'b1, 241, 1));    // 256 wide: refused
    send_word(make_word(OP_ALLOC, 1'b1, 240, 1));
    send_word(make_word(OP_ALLOC, 1'b1, 1, 1));
    write_pad(PAD_W'(0));
    send_word(make_word(OP_ALLOC, 1'b1, 256, 1));
    send_word(make_word(OP_ALLOC, 1'b1, 255, 1));
    send_word(make_word(OP_ALLOC, 1'b1, 0, 0));
    send_word(make_word(OP_UPLOAD, 1'b1, 0, 0));
  endtask

  // Bursts of random words with random gaps, over several pad settings.
  task automatic test_random_traffic(input int per_phase);
    logic [PAD_W-1:0] pads [5];
    int sent;
    int burst;
    pads = '{PAD_W'(0), PAD_W'(15), PAD_W'($urandom), PAD_W'(2), PAD_W'($urandom)};
    foreach (pads[p]) begin
      write_pad(pads[p]);
      sent = 0;
      while (sent < per_phase) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst && sent < per_phase; k++) begin
          send_word(random_word());
          sent++;
        end
        // Back-to-back stretches as well as gaps of various lengths.
        if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 20));
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    errors      = 0;
    placed_cnt  = 0;
    no_room_cnt = 0;
    upload_cnt  = 0;
    foreach (fill_height[p, c]) fill_height[p][c] = 0;
    dirty_bits = '0;
    pad_model  = PAD_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // The first word waits out the clearing pass on busy.
    test_reset_pad_edges();
    test_pad_extremes();
    test_random_traffic(260);

    drain();
    repeat (30) @(posedge clk);
    $display("covered %0d placements, %0d refusals and %0d uploads",
             placed_cnt, no_room_cnt, upload_cnt);
    $display("pad settings 2, 0, 15 and random, both pages, sizes 0 to 511");
    if (errors == 0) begin
      $display("skyline_atlas_allocator_unit verification clean");
    end else begin
      $display("skyline_atlas_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
